// ===== design/slcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcc_pkg
// Shared types, character codes and helpers of the serial LED command
// controller.
// ----------------------------------------------------------------------------
package slcc_pkg;

   localparam int MAX_LEDS    = 3;
   localparam int MAX_SECONDS = 9;

   typedef enum logic [1:0] {
      MODE_KEEP  = 2'd0,
      MODE_ON    = 2'd1,
      MODE_OFF   = 2'd2,
      MODE_BLINK = 2'd3
   } led_mode_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_ON    = 3'd1,
      KIND_OFF   = 3'd2,
      KIND_BLINK = 3'd3,
      KIND_RESET = 3'd4
   } cmd_kind_type;

   localparam logic [7:0] CHAR_0 = "0";
   localparam logic [7:0] CHAR_1 = "1";
   localparam logic [7:0] CHAR_4 = "4";
   localparam logic [7:0] CHAR_9 = "9";
   localparam logic [7:0] CHAR_B = "b";
   localparam logic [7:0] CHAR_D = "d";
   localparam logic [7:0] CHAR_E = "e";
   localparam logic [7:0] CHAR_F = "f";
   localparam logic [7:0] CHAR_I = "i";
   localparam logic [7:0] CHAR_K = "k";
   localparam logic [7:0] CHAR_L = "l";
   localparam logic [7:0] CHAR_N = "n";
   localparam logic [7:0] CHAR_O = "o";
   localparam logic [7:0] CHAR_R = "r";
   localparam logic [7:0] CHAR_S = "s";
   localparam logic [7:0] CHAR_T = "t";

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   led;
      logic [3:0]   seconds;
   } cmd_type;

   typedef struct packed {
      logic       tick;
      logic       set_on;
      logic       set_off;
      logic       set_blink;
      logic [3:0] seconds;
   } led_ctl_type;

   function automatic logic is_led_digit(input logic [7:0] ch);
      return (ch > CHAR_0) && (ch < CHAR_4);
   endfunction

endpackage
`default_nettype wire

// ===== design/slcc_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcc_match
// Character-at-a-time command matcher: tracks the match position, the first
// and previous characters and the addressed LED, and reports completed
// commands.
// ----------------------------------------------------------------------------
module slcc_match import slcc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] ch,
   output cmd_type         cmd
);

   logic [3:0] pos_ff, pos_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] prev_ff, prev_in;
   logic [1:0] target_ff, target_in;

   logic [3:0]   next_pos;
   cmd_kind_type kind;

   always_comb begin
      next_pos = 4'd0;
      kind     = KIND_NONE;
      case (pos_ff)
         4'd0: begin
            if (ch == CHAR_L || ch == CHAR_R) next_pos = 4'd1;
         end
         4'd1: begin
            if (ch == CHAR_E) next_pos = 4'd2;
         end
         4'd2: begin
            if ((ch == CHAR_D && first_ff == CHAR_L) ||
                (ch == CHAR_S && first_ff == CHAR_R)) next_pos = 4'd3;
         end
         4'd3: begin
            if ((is_led_digit(ch) && prev_ff == CHAR_D) ||
                (ch == CHAR_E && prev_ff == CHAR_S)) next_pos = 4'd4;
         end
         4'd4: begin
            if (ch == CHAR_T && prev_ff == CHAR_E) begin
               kind = KIND_RESET;
            end else if ((ch == CHAR_O || ch == CHAR_B) && is_led_digit(prev_ff)) begin
               next_pos = 4'd5;
            end
         end
         4'd5: begin
            if (ch == CHAR_N && prev_ff == CHAR_O) begin
               kind = KIND_ON;
            end else if ((ch == CHAR_F && prev_ff == CHAR_O) ||
                         (ch == CHAR_L && prev_ff == CHAR_B)) begin
               next_pos = 4'd6;
            end
         end
         4'd6: begin
            if (ch == CHAR_F && prev_ff == CHAR_F) begin
               kind = KIND_OFF;
            end else if (ch == CHAR_I && prev_ff == CHAR_L) begin
               next_pos = 4'd7;
            end
         end
         4'd7: begin
            if (ch == CHAR_N && prev_ff == CHAR_I) next_pos = 4'd8;
         end
         4'd8: begin
            if (ch == CHAR_K && prev_ff == CHAR_N) next_pos = 4'd9;
         end
         4'd9: begin
            if (ch > CHAR_0 && ch <= CHAR_9 && prev_ff == CHAR_K) kind = KIND_BLINK;
         end
         default: begin
            next_pos = 4'd0;
         end
      endcase
      if (!step) kind = KIND_NONE;
   end

   always_comb begin
      pos_in    = pos_ff;
      first_in  = first_ff;
      prev_in   = prev_ff;
      target_in = target_ff;
      if (step) begin
         pos_in  = next_pos;
         prev_in = ch;
         if (pos_ff == 4'd0) first_in = ch;
         if (pos_ff == 4'd3 && is_led_digit(ch)) target_in = 2'(ch - CHAR_1);
      end
   end

   always_comb begin
      cmd.kind    = kind;
      cmd.led     = (kind == KIND_NONE || kind == KIND_RESET) ? 2'd0 : target_ff;
      cmd.seconds = (kind == KIND_BLINK) ? 4'(ch - CHAR_0) : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         first_ff  <= '0;
         prev_ff   <= '0;
         target_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         prev_ff   <= prev_in;
         target_ff <= target_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/slcc_led.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcc_led
// One LED channel: mode, level, blink period and tick countdown.
// ----------------------------------------------------------------------------
module slcc_led import slcc_pkg::*; #(
   parameter int TICKS_PER_SECOND = 10
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire led_ctl_type ctl,
   output logic       level_next
);

   localparam int WAIT_W = $clog2(MAX_SECONDS * TICKS_PER_SECOND + 1);

   led_mode_type      mode_ff, mode_in;
   logic              level_ff, level_in;
   logic [3:0]        period_ff, period_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [WAIT_W-1:0] reload;

   assign reload = WAIT_W'(period_ff * TICKS_PER_SECOND);

   always_comb begin
      mode_in   = mode_ff;
      level_in  = level_ff;
      period_in = period_ff;
      wait_in   = wait_ff;
      if (ctl.tick) begin
         if (wait_ff > WAIT_W'(1)) begin
            wait_in = wait_ff - WAIT_W'(1);
         end else begin
            wait_in = WAIT_W'(1);
            case (mode_ff)
               MODE_ON:    level_in = 1'b1;
               MODE_OFF:   level_in = 1'b0;
               MODE_BLINK: begin
                  level_in = ~level_ff;
                  if (reload != '0) wait_in = reload;
               end
               default:    level_in = level_ff;
            endcase
         end
      end else if (ctl.set_on) begin
         mode_in  = MODE_ON;
         level_in = 1'b1;
         wait_in  = WAIT_W'(1);
      end else if (ctl.set_off) begin
         mode_in  = MODE_OFF;
         level_in = 1'b0;
         wait_in  = WAIT_W'(1);
      end else if (ctl.set_blink) begin
         mode_in   = MODE_BLINK;
         period_in = ctl.seconds;
      end
   end

   assign level_next = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_KEEP;
         level_ff  <= 1'b0;
         period_ff <= '0;
         wait_ff   <= WAIT_W'(1);
      end else begin
         mode_ff   <= mode_in;
         level_ff  <= level_in;
         period_ff <= period_in;
         wait_ff   <= wait_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/serial_led_command_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_led_command_controller
// Serial command matcher and LED driver.
// ----------------------------------------------------------------------------
// Input stream (req_): one word per received serial byte or per 100 ms tick;
// req_tuser selects which. Every input word yields exactly one result word
// (rsp_) with the LED levels after the step, the echoed byte and the command
// completed by that byte, if any.
// A word accepted on req_ passes the input register, then the result register,
// before it is presented on rsp_. Throughput: one word per cycle while the
// receiver does not stall; the command match and the per-LED counter updates
// are combinational between the two registers.
// Reset clears the matcher, turns all LEDs off in keep mode and empties both
// registers. When the receiver stalls, the result word holds and the input
// register still takes one more word; req_tready then drops until rsp_tready
// returns.
// ----------------------------------------------------------------------------
module serial_led_command_controller import slcc_pkg::*; #(
   parameter int LED_COUNT        = 3,
   parameter int TICKS_PER_SECOND = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  wire logic        req_tuser,  // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // [2:0] led_levels, [10:3] echo_byte,
                                        // [13:11] cmd_kind, [15:14] cmd_led,
                                        // [19:16] cmd_seconds, [23:20] zero
   output logic             rsp_tuser   // [0] echo_valid
);

   logic        in_valid_ff, in_valid_in;
   logic        in_action_ff;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   logic                advance;
   logic                byte_step;
   logic                tick_step;
   cmd_type             cmd;
   logic [MAX_LEDS-1:0] levels;
   logic [7:0]          echo;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign byte_step  = advance && !in_action_ff;
   assign tick_step  = advance && in_action_ff;

   slcc_match u_match (
      .clock (clock),
      .reset (reset),
      .step  (byte_step),
      .ch    (in_byte_ff),
      .cmd   (cmd)
   );

   for (genvar i = 0; i < MAX_LEDS; i++) begin : g_led
      if (i < LED_COUNT) begin : g_on
         led_ctl_type ctl;
         always_comb begin
            ctl.tick      = tick_step;
            ctl.set_on    = (cmd.kind == KIND_ON) && (cmd.led == 2'(i));
            ctl.set_off   = ((cmd.kind == KIND_OFF) && (cmd.led == 2'(i))) ||
                            (cmd.kind == KIND_RESET);
            ctl.set_blink = (cmd.kind == KIND_BLINK) && (cmd.led == 2'(i));
            ctl.seconds   = cmd.seconds;
         end
         slcc_led #(
            .TICKS_PER_SECOND (TICKS_PER_SECOND)
         ) u_led (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .level_next (levels[i])
         );
      end else begin : g_off
         assign levels[i] = 1'b0;
      end
   end

   assign echo = in_action_ff ? 8'd0 : in_byte_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (req_tready) in_valid_in = req_tvalid;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'd0, cmd.seconds, cmd.led, cmd.kind, echo, levels};
         rsp_user_in  = !in_action_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= req_tuser;
         in_byte_ff   <= req_tdata;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ===== design/slcc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slcc_checker
// Port-level checks of the serial LED command controller, bound to the top.
// ----------------------------------------------------------------------------
module slcc_checker import slcc_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[19:3] == 17'd0)
      else $error("tick word carries echo or command");

   a_no_cmd_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13:11] == KIND_NONE |-> rsp_tdata[19:14] == 6'd0)
      else $error("command fields set without a command");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[13:11] <= KIND_RESET) && (rsp_tdata[23:20] == 4'd0))
      else $error("bad command kind or padding");

endmodule

bind serial_led_command_controller slcc_checker u_slcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== bench/serial_led_command_controller_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_led_command_controller_checker
// Watches both streams of the LED command controller, keeps its own model of
// the command matcher and the LED timers, and compares every result word
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module serial_led_command_controller_checker import slcc_pkg::*; #(
   parameter int LED_COUNT        = 3,
   parameter int TICKS_PER_SECOND = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [2:0] led_levels, [10:3] echo_byte,
                                    // [13:11] cmd_kind, [15:14] cmd_led,
                                    // [19:16] cmd_seconds, [23:20] zero
   input  logic        rsp_tuser,   // [0] echo_valid
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [2:0]   levels;
      logic         echo_valid;
      logic [7:0]   echo_byte;
      cmd_kind_type kind;
      logic [1:0]   led;
      logic [3:0]   seconds;
   } led_report_type;

   led_report_type led_reports[$];

   logic [3:0]   match_pos;
   logic [7:0]   first_ch;
   logic [7:0]   prev_ch;
   logic [1:0]   target;
   led_mode_type mode_q[3];
   logic         level_q[3];
   logic [3:0]   period_q[3];
   int           wait_q[3];

   function automatic bit addresses_led(input logic [7:0] c);
      return (c > CHAR_0) && (c < CHAR_4);
   endfunction

   // next match position; 0 on mismatch or on a finished command
   function automatic logic [3:0] match_next(input logic [7:0] c,
                                             output cmd_kind_type done);
      done = KIND_NONE;
      case (match_pos)
         4'd0: if (c == CHAR_L || c == CHAR_R) return 4'd1;
         4'd1: if (c == CHAR_E) return 4'd2;
         4'd2: begin
            if (c == CHAR_D && first_ch == CHAR_L) return 4'd3;
            if (c == CHAR_S && first_ch == CHAR_R) return 4'd3;
         end
         4'd3: begin
            if (addresses_led(c) && prev_ch == CHAR_D) return 4'd4;
            if (c == CHAR_E && prev_ch == CHAR_S) return 4'd4;
         end
         4'd4: begin
            if (c == CHAR_T && prev_ch == CHAR_E) begin
               done = KIND_RESET;
               return 4'd0;
            end
            if ((c == CHAR_O || c == CHAR_B) && addresses_led(prev_ch)) return 4'd5;
         end
         4'd5: begin
            if (c == CHAR_N && prev_ch == CHAR_O) begin
               done = KIND_ON;
               return 4'd0;
            end
            if (c == CHAR_F && prev_ch == CHAR_O) return 4'd6;
            if (c == CHAR_L && prev_ch == CHAR_B) return 4'd6;
         end
         4'd6: begin
            if (c == CHAR_F && prev_ch == CHAR_F) begin
               done = KIND_OFF;
               return 4'd0;
            end
            if (c == CHAR_I && prev_ch == CHAR_L) return 4'd7;
         end
         4'd7: if (c == CHAR_N && prev_ch == CHAR_I) return 4'd8;
         4'd8: if (c == CHAR_K && prev_ch == CHAR_N) return 4'd9;
         4'd9: begin
            if (c > CHAR_0 && c <= CHAR_9 && prev_ch == CHAR_K) begin
               done = KIND_BLINK;
               return 4'd0;
            end
         end
         default: ;
      endcase
      return 4'd0;
   endfunction

   task automatic set_led(input int i, input led_mode_type m);
      mode_q[i]  = m;
      level_q[i] = (m == MODE_ON);
      wait_q[i]  = 1;
   endtask

   task automatic tick_leds();
      int w;
      for (int i = 0; i < LED_COUNT && i < 3; i++) begin
         if (wait_q[i] > 1) begin
            wait_q[i]--;
         end else begin
            case (mode_q[i])
               MODE_ON: begin
                  level_q[i] = 1'b1;
                  wait_q[i]  = 1;
               end
               MODE_OFF: begin
                  level_q[i] = 1'b0;
                  wait_q[i]  = 1;
               end
               MODE_BLINK: begin
                  level_q[i] = ~level_q[i];
                  w = int'(period_q[i]) * TICKS_PER_SECOND;
                  wait_q[i] = (w == 0) ? 1 : w;
               end
               default: wait_q[i] = 1;
            endcase
         end
      end
   endtask

   task automatic clear_state();
      match_pos = '0;
      first_ch  = '0;
      prev_ch   = '0;
      target    = '0;
      for (int i = 0; i < 3; i++) begin
         mode_q[i]   = MODE_KEEP;
         level_q[i]  = 1'b0;
         period_q[i] = '0;
         wait_q[i]   = 1;
      end
      led_reports.delete();
   endtask

   task automatic step_controller(input logic act, input logic [7:0] ch);
      led_report_type r;
      cmd_kind_type   done;
      logic [3:0]     nxt;
      r = '0;
      if (act) begin
         tick_leds();
      end else begin
         nxt = match_next(ch, done);
         if (match_pos == 4'd0) first_ch = ch;
         if (match_pos == 4'd3 && addresses_led(ch)) target = 2'(ch - CHAR_1);
         prev_ch      = ch;
         match_pos    = nxt;
         r.echo_valid = 1'b1;
         r.echo_byte  = ch;
         r.kind       = done;
         if (done == KIND_RESET) begin
            for (int i = 0; i < LED_COUNT && i < 3; i++) set_led(i, MODE_OFF);
         end else if (done != KIND_NONE) begin
            r.led = target;
            if (done == KIND_BLINK) r.seconds = 4'(ch - CHAR_0);
            if (int'(target) < LED_COUNT) begin
               case (done)
                  KIND_ON:  set_led(target, MODE_ON);
                  KIND_OFF: set_led(target, MODE_OFF);
                  default: begin
                     mode_q[target]   = MODE_BLINK;
                     period_q[target] = r.seconds;
                  end
               endcase
            end
         end
      end
      for (int i = 0; i < LED_COUNT && i < 3; i++) r.levels[i] = level_q[i];
      led_reports.push_back(r);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      led_report_type want;
      if (reset) begin
         clear_state();
         errors = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (led_reports.size() == 0) begin
               $error("result word with no word outstanding");
               errors++;
            end else begin
               want = led_reports.pop_front();
               check_field("led_levels", want.levels, rsp_tdata[2:0]);
               check_field("echo_valid", want.echo_valid, rsp_tuser);
               check_field("echo_byte", want.echo_byte, rsp_tdata[10:3]);
               check_field("cmd_kind", int'(want.kind), rsp_tdata[13:11]);
               check_field("cmd_led", want.led, rsp_tdata[15:14]);
               check_field("cmd_seconds", want.seconds, rsp_tdata[19:16]);
               check_field("pad", 0, rsp_tdata[23:20]);
            end
         end
         if (req_tvalid && req_tready) step_controller(req_tuser, req_tdata);
      end
      pending = led_reports.size();
   end

endmodule

// ===== bench/serial_led_command_controller_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_led_command_controller_test
// Drives the LED command controller with a short directed sequence, then
// random commands (whole, truncated or corrupted), tick runs and noise bytes,
// under bursty input and a stalling receiver with one long hold-off.
// ----------------------------------------------------------------------------
module serial_led_command_controller_test import slcc_pkg::*;;

   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam int         WORD_TARGET = 1525;
   localparam int         CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        req_tuser;   // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [2:0] led_levels, [10:3] echo_byte, [13:11] cmd_kind,
                             // [15:14] cmd_led, [19:16] cmd_seconds, [23:20] zero
   logic        rsp_tuser;   // [0] echo_valid
   int          errors;
   int          pending;
   int          burst_left = 0;
   int          sent_count = 0;
   int          cycles     = 0;

   always #5 clock = ~clock;

   serial_led_command_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   serial_led_command_controller_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .errors     (errors),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("serial_led_command_controller regression: fail");
         $finish;
      end
   end

   // bursts of words with random gaps between them
   task automatic send_word(input logic act, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
   endtask

   task automatic send_command();
      logic [7:0] text[$];
      logic [7:0] digit;
      logic [7:0] secs;
      int         pick;
      int         count;
      digit = CHAR_1 + 8'($urandom_range(0, 2));
      secs  = CHAR_0 + 8'($urandom_range(1, ($urandom_range(0, 2) == 0) ? 9 : 2));
      pick  = $urandom_range(0, 9);
      if (pick < 3)
         text = {CHAR_L, CHAR_E, CHAR_D, digit, CHAR_O, CHAR_N};
      else if (pick < 6)
         text = {CHAR_L, CHAR_E, CHAR_D, digit, CHAR_O, CHAR_F, CHAR_F};
      else if (pick < 9)
         text = {CHAR_L, CHAR_E, CHAR_D, digit, CHAR_B, CHAR_L, CHAR_I, CHAR_N, CHAR_K, secs};
      else
         text = {CHAR_R, CHAR_E, CHAR_S, CHAR_E, CHAR_T};
      count = text.size();
      if ($urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 1) == 0) begin
            count = $urandom_range(1, text.size() - 1);
         end else begin
            case ($urandom_range(0, 3))
               0:       text[$urandom_range(0, count - 1)] = CHAR_0;
               1:       text[$urandom_range(0, count - 1)] = CHAR_4;
               2:       text[$urandom_range(0, count - 1)] = CHAR_CR;
               default: text[$urandom_range(0, count - 1)] = 8'($urandom_range(0, 255));
            endcase
         end
      end
      for (int i = 0; i < count; i++) send_word(1'b0, text[i]);
   endtask

   initial begin : stimulus
      int pick;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_text("led1on");
      send_word(1'b0, 8'hff);
      send_word(1'b0, 8'h00);
      send_word(1'b0, CHAR_CR);
      send_text("led3blink1");
      send_word(1'b1, 8'($urandom_range(0, 255)));
      send_text("reset");

      while (sent_count < WORD_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            repeat ($urandom_range(1, 60)) send_word(1'b1, 8'($urandom_range(0, 255)));
         end else if (pick < 85) begin
            send_command();
         end else begin
            repeat ($urandom_range(1, 6)) send_word(1'b0, 8'($urandom_range(0, 255)));
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("serial_led_command_controller regression: pass");
      end else begin
         $display("serial_led_command_controller regression: fail");
      end
      $finish;
   end

   // receiver: ready runs, random stalls, dead stretches, one long hold-off
   initial begin : receiver
      int pick;
      int run;
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && sent_count >= 400) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         pick = $urandom_range(0, 9);
         run  = $urandom_range(1, 40);
         repeat (run) begin
            if (pick < 4)
               rsp_tready <= 1'b1;
            else if (pick < 8)
               rsp_tready <= 1'($urandom_range(0, 1));
            else
               rsp_tready <= ($urandom_range(0, 7) == 0);
            @(posedge clock);
         end
      end
   end

endmodule
